// File: design/emr_pkg.sv
// Package with the sequencer state type and command codes of the ellipse rasterizer.
`default_nettype none

package emr_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_MUL_RX2 = 15'b000000000000010,
        ST_MUL_RY2 = 15'b000000000000100,
        ST_MUL_GY  = 15'b000000000001000,
        ST_INIT_D  = 15'b000000000010000,
        ST_CHECK   = 15'b000000000100000,
        ST_STEP_A  = 15'b000000001000000,
        ST_STEP_D  = 15'b000000010000000,
        ST_SET_1   = 15'b000000100000000,
        ST_SET_2   = 15'b000001000000000,
        ST_SET_3   = 15'b000010000000000,
        ST_SET_4   = 15'b000100000000000,
        ST_SET_5   = 15'b001000000000000,
        ST_SET_6   = 15'b010000000000000,
        ST_EMIT    = 15'b100000000000000
    } state_t;

endpackage

`default_nettype wire

// File: design/emr_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none

module emr_mul #(
    parameter int OP_W = 26
) (
    input  wire logic                aclk,
    input  wire logic [OP_W-1:0]     op_a,
    input  wire logic [OP_W-1:0]     op_b,
    output logic      [2*OP_W-1:0]   prod
);

    logic [2*OP_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: design/emr_core.sv
// Sequencer and datapath that step the midpoint ellipse walk using the shared multiplier.
`default_nettype none

module emr_core #(
    parameter int COORD_WIDTH  = 12,
    parameter int RADIUS_WIDTH = 11
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [COORD_WIDTH-1:0]        center_x,
    input  wire logic [COORD_WIDTH-1:0]        center_y,
    input  wire logic [RADIUS_WIDTH-1:0]       radius_x,
    input  wire logic [RADIUS_WIDTH-1:0]       radius_y,
    input  wire logic                          out_free,
    output logic                               res_emit,
    output logic                               res_valid_res,
    output logic [COORD_WIDTH+1:0]             res_x_right,
    output logic [COORD_WIDTH+1:0]             res_x_left,
    output logic [COORD_WIDTH+1:0]             res_y_lower,
    output logic [COORD_WIDTH+1:0]             res_y_upper,
    output logic                               res_last
);

    localparam int OFS_W  = RADIUS_WIDTH + 1;
    localparam int SQ_W   = 2 * RADIUS_WIDTH;
    localparam int MOP_W  = 2 * RADIUS_WIDTH + 4;
    localparam int DEC_W  = 2 * MOP_W;
    localparam int GRAD_W = 3 * RADIUS_WIDTH + 3;
    localparam int OUT_W  = COORD_WIDTH + 2;

    emr_pkg::state_t state_reg, state_next;

    logic [COORD_WIDTH-1:0]  ctr_x_reg, ctr_x_next, ctr_y_reg, ctr_y_next;
    logic [RADIUS_WIDTH-1:0] semi_x_reg, semi_x_next, semi_y_reg, semi_y_next;
    logic [OFS_W-1:0]        ofs_x_reg, ofs_x_next, ofs_y_reg, ofs_y_next;
    logic [SQ_W-1:0]         rx2_reg, rx2_next, ry2_reg, ry2_next;
    logic [DEC_W-1:0]        dec_reg, dec_next;
    logic [GRAD_W-1:0]       gx_reg, gx_next, gy_reg, gy_next;
    logic [MOP_W-1:0]        tmp_reg, tmp_next;
    logic                    r2_reg, r2_next;
    logic                    drawing_reg, drawing_next;
    logic                    null_reg, null_next;
    logic                    mvx_reg, mvx_next, mvy_reg, mvy_next;

    logic [MOP_W-1:0]  mul_a, mul_b;
    logic [DEC_W-1:0]  prod;
    logic [DEC_W-1:0]  prod_x4;
    logic [OFS_W:0]    tx;
    logic [OFS_W-1:0]  ym;
    logic              dec_neg, dec_pos;
    logic              move_x, move_y;
    logic              gx_lt_gy;
    logic [GRAD_W-1:0] ry2_x2, rx2_x2;
    logic [DEC_W-1:0]  ry2_x4, rx2_x4, gx_x4, gy_x4;

    emr_mul #(.OP_W(MOP_W)) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign prod_x4  = {prod[DEC_W-3:0], 2'b00};
    assign tx       = {ofs_x_reg, 1'b1};
    assign ym       = (ofs_y_reg == '0) ? OFS_W'(1) : ofs_y_reg - OFS_W'(1);
    assign dec_neg  = dec_reg[DEC_W-1];
    assign dec_pos  = !dec_reg[DEC_W-1] && (dec_reg != '0);
    assign move_x   = !r2_reg || !dec_pos;
    assign move_y   = r2_reg || !dec_neg;
    assign gx_lt_gy = gx_reg < gy_reg;
    assign ry2_x2   = GRAD_W'({ry2_reg, 1'b0});
    assign rx2_x2   = GRAD_W'({rx2_reg, 1'b0});
    assign ry2_x4   = DEC_W'({ry2_reg, 2'b00});
    assign rx2_x4   = DEC_W'({rx2_reg, 2'b00});
    assign gx_x4    = DEC_W'({gx_reg, 2'b00});
    assign gy_x4    = DEC_W'({gy_reg, 2'b00});

    assign in_ready      = (state_reg == emr_pkg::ST_IDLE);
    assign res_valid_res = !null_reg;
    assign res_x_right   = null_reg ? '0 : OUT_W'(ctr_x_reg) + OUT_W'(ofs_x_reg);
    assign res_x_left    = null_reg ? '0 : OUT_W'(ctr_x_reg) - OUT_W'(ofs_x_reg);
    assign res_y_lower   = null_reg ? '0 : OUT_W'(ctr_y_reg) + OUT_W'(ofs_y_reg);
    assign res_y_upper   = null_reg ? '0 : OUT_W'(ctr_y_reg) - OUT_W'(ofs_y_reg);
    assign res_last      = !null_reg && (ofs_y_reg == '0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            emr_pkg::ST_MUL_RX2: begin
                mul_a = MOP_W'(semi_x_reg);
                mul_b = MOP_W'(semi_x_reg);
            end
            emr_pkg::ST_MUL_RY2: begin
                mul_a = MOP_W'(semi_y_reg);
                mul_b = MOP_W'(semi_y_reg);
            end
            emr_pkg::ST_MUL_GY: begin
                mul_a = MOP_W'(rx2_reg);
                mul_b = MOP_W'(semi_y_reg);
            end
            emr_pkg::ST_SET_1: begin
                mul_a = MOP_W'(tx);
                mul_b = MOP_W'(tx);
            end
            emr_pkg::ST_SET_2: begin
                mul_a = MOP_W'(ym);
                mul_b = MOP_W'(ym);
            end
            emr_pkg::ST_SET_3: begin
                mul_a = MOP_W'(ry2_reg);
                mul_b = tmp_reg;
            end
            emr_pkg::ST_SET_4: begin
                mul_a = MOP_W'(rx2_reg);
                mul_b = tmp_reg;
            end
            emr_pkg::ST_SET_5: begin
                mul_a = MOP_W'(rx2_reg);
                mul_b = MOP_W'(ry2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        ctr_x_next   = ctr_x_reg;
        ctr_y_next   = ctr_y_reg;
        semi_x_next  = semi_x_reg;
        semi_y_next  = semi_y_reg;
        ofs_x_next   = ofs_x_reg;
        ofs_y_next   = ofs_y_reg;
        rx2_next     = rx2_reg;
        ry2_next     = ry2_reg;
        dec_next     = dec_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        tmp_next     = tmp_reg;
        r2_next      = r2_reg;
        drawing_next = drawing_reg;
        null_next    = null_reg;
        mvx_next     = mvx_reg;
        mvy_next     = mvy_reg;
        res_emit     = 1'b0;
        case (state_reg)
            emr_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (cmd == emr_pkg::CMD_START) begin
                        ctr_x_next   = center_x;
                        ctr_y_next   = center_y;
                        semi_x_next  = radius_x;
                        semi_y_next  = radius_y;
                        ofs_x_next   = '0;
                        ofs_y_next   = OFS_W'(radius_y);
                        gx_next      = '0;
                        r2_next      = 1'b0;
                        drawing_next = 1'b1;
                        null_next    = 1'b0;
                        state_next   = emr_pkg::ST_MUL_RX2;
                    end else if (drawing_reg) begin
                        null_next  = 1'b0;
                        state_next = emr_pkg::ST_STEP_A;
                    end else begin
                        null_next  = 1'b1;
                        state_next = emr_pkg::ST_EMIT;
                    end
                end
            end
            emr_pkg::ST_MUL_RX2: begin
                state_next = emr_pkg::ST_MUL_RY2;
            end
            emr_pkg::ST_MUL_RY2: begin
                rx2_next   = prod[SQ_W-1:0];
                state_next = emr_pkg::ST_MUL_GY;
            end
            emr_pkg::ST_MUL_GY: begin
                ry2_next   = prod[SQ_W-1:0];
                dec_next   = prod_x4 + DEC_W'(rx2_reg);
                state_next = emr_pkg::ST_INIT_D;
            end
            emr_pkg::ST_INIT_D: begin
                gy_next    = {prod[GRAD_W-2:0], 1'b0};
                dec_next   = dec_reg - prod_x4;
                state_next = emr_pkg::ST_CHECK;
            end
            emr_pkg::ST_CHECK: begin
                state_next = (!r2_reg && !gx_lt_gy) ? emr_pkg::ST_SET_1 : emr_pkg::ST_EMIT;
            end
            emr_pkg::ST_STEP_A: begin
                mvx_next = move_x;
                mvy_next = move_y;
                if (move_x) begin
                    ofs_x_next = ofs_x_reg + OFS_W'(1);
                    gx_next    = gx_reg + ry2_x2;
                end
                if (move_y) begin
                    ofs_y_next = ofs_y_reg - OFS_W'(1);
                    gy_next    = gy_reg - rx2_x2;
                end
                dec_next   = dec_reg + (r2_reg ? rx2_x4 : ry2_x4);
                state_next = emr_pkg::ST_STEP_D;
            end
            emr_pkg::ST_STEP_D: begin
                dec_next = dec_reg + (mvx_reg ? gx_x4 : '0) - (mvy_reg ? gy_x4 : '0);
                if (!r2_reg && !gx_lt_gy) begin
                    state_next = emr_pkg::ST_SET_1;
                end else if (out_free) begin
                    res_emit   = 1'b1;
                    if (ofs_y_reg == '0) begin
                        drawing_next = 1'b0;
                    end
                    state_next = emr_pkg::ST_IDLE;
                end else begin
                    state_next = emr_pkg::ST_EMIT;
                end
            end
            emr_pkg::ST_SET_1: begin
                state_next = emr_pkg::ST_SET_2;
            end
            emr_pkg::ST_SET_2: begin
                tmp_next   = prod[MOP_W-1:0];
                state_next = emr_pkg::ST_SET_3;
            end
            emr_pkg::ST_SET_3: begin
                tmp_next   = prod[MOP_W-1:0];
                state_next = emr_pkg::ST_SET_4;
            end
            emr_pkg::ST_SET_4: begin
                dec_next   = prod;
                state_next = emr_pkg::ST_SET_5;
            end
            emr_pkg::ST_SET_5: begin
                dec_next   = dec_reg + prod_x4;
                state_next = emr_pkg::ST_SET_6;
            end
            emr_pkg::ST_SET_6: begin
                dec_next   = dec_reg - prod_x4;
                r2_next    = 1'b1;
                state_next = emr_pkg::ST_EMIT;
            end
            emr_pkg::ST_EMIT: begin
                if (out_free) begin
                    res_emit = 1'b1;
                    if (!null_reg && (ofs_y_reg == '0)) begin
                        drawing_next = 1'b0;
                    end
                    state_next = emr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = emr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= emr_pkg::ST_IDLE;
            ctr_x_reg   <= '0;
            ctr_y_reg   <= '0;
            semi_x_reg  <= '0;
            semi_y_reg  <= '0;
            ofs_x_reg   <= '0;
            ofs_y_reg   <= '0;
            dec_reg     <= '0;
            gx_reg      <= '0;
            gy_reg      <= '0;
            r2_reg      <= 1'b0;
            drawing_reg <= 1'b0;
            null_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ctr_x_reg   <= ctr_x_next;
            ctr_y_reg   <= ctr_y_next;
            semi_x_reg  <= semi_x_next;
            semi_y_reg  <= semi_y_next;
            ofs_x_reg   <= ofs_x_next;
            ofs_y_reg   <= ofs_y_next;
            dec_reg     <= dec_next;
            gx_reg      <= gx_next;
            gy_reg      <= gy_next;
            r2_reg      <= r2_next;
            drawing_reg <= drawing_next;
            null_reg    <= null_next;
        end
    end

    always_ff @(posedge aclk) begin
        rx2_reg <= rx2_next;
        ry2_reg <= ry2_next;
        tmp_reg <= tmp_next;
        mvx_reg <= mvx_next;
        mvy_reg <= mvy_next;
    end

endmodule

`default_nettype wire

// File: design/midpoint_ellipse_rasterizer_top.sv
// Flow: a next-point transfer steps through ST_STEP_A and ST_STEP_D and then registers its
// result, and the input is ready again once that result is taken into the output register.
// A start transfer first squares the radii and sets up the decision term and gradients;
// entering region two runs the ST_SET_1 to ST_SET_6 states on a start or a next-point transfer.
// The sequencer runs one item at a time; the output register lets a new item enter while a
// result waits. Reset is synchronous and active low and leaves the block idle with no ellipse.
`default_nettype none

module midpoint_ellipse_rasterizer_top #(
    parameter int COORD_WIDTH  = 12,
    parameter int RADIUS_WIDTH = 11
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [COORD_WIDTH-1:0]        s_center_x,
    input  wire logic [COORD_WIDTH-1:0]        s_center_y,
    input  wire logic [RADIUS_WIDTH-1:0]       s_radius_x,
    input  wire logic [RADIUS_WIDTH-1:0]       s_radius_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_valid_res,
    output logic signed [COORD_WIDTH+1:0]      m_x_right,
    output logic signed [COORD_WIDTH+1:0]      m_x_left,
    output logic signed [COORD_WIDTH+1:0]      m_y_lower,
    output logic signed [COORD_WIDTH+1:0]      m_y_upper,
    output logic                               m_last
);

    localparam int OUT_W = COORD_WIDTH + 2;

    logic             out_free;
    logic             res_emit;
    logic             res_valid_res, res_last;
    logic [OUT_W-1:0] res_x_right, res_x_left, res_y_lower, res_y_upper;

    logic             m_valid_reg;
    logic             valid_res_reg, last_reg;
    logic [OUT_W-1:0] x_right_reg, x_left_reg, y_lower_reg, y_upper_reg;

    assign out_free = !m_valid_reg || m_ready;

    emr_core #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .cmd           (s_cmd),
        .center_x      (s_center_x),
        .center_y      (s_center_y),
        .radius_x      (s_radius_x),
        .radius_y      (s_radius_y),
        .out_free      (out_free),
        .res_emit      (res_emit),
        .res_valid_res (res_valid_res),
        .res_x_right   (res_x_right),
        .res_x_left    (res_x_left),
        .res_y_lower   (res_y_lower),
        .res_y_upper   (res_y_upper),
        .res_last      (res_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_emit) begin
            valid_res_reg <= res_valid_res;
            x_right_reg   <= res_x_right;
            x_left_reg    <= res_x_left;
            y_lower_reg   <= res_y_lower;
            y_upper_reg   <= res_y_upper;
            last_reg      <= res_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_valid_res = valid_res_reg;
    assign m_x_right   = $signed(x_right_reg);
    assign m_x_left    = $signed(x_left_reg);
    assign m_y_lower   = $signed(y_lower_reg);
    assign m_y_upper   = $signed(y_upper_reg);
    assign m_last      = last_reg;

endmodule

`default_nettype wire

// File: design/emr_checker.sv
// Port-level checker for the ellipse rasterizer and its bind to the top level.
`default_nettype none

module emr_checker #(
    parameter int COORD_WIDTH  = 12,
    parameter int RADIUS_WIDTH = 11
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          s_cmd,
    input wire logic [COORD_WIDTH-1:0]        s_center_x,
    input wire logic [COORD_WIDTH-1:0]        s_center_y,
    input wire logic [RADIUS_WIDTH-1:0]       s_radius_x,
    input wire logic [RADIUS_WIDTH-1:0]       s_radius_y,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_valid_res,
    input wire logic signed [COORD_WIDTH+1:0] m_x_right,
    input wire logic signed [COORD_WIDTH+1:0] m_x_left,
    input wire logic signed [COORD_WIDTH+1:0] m_y_lower,
    input wire logic signed [COORD_WIDTH+1:0] m_y_upper,
    input wire logic                          m_last
);

    // A stalled result must hold its payload until the transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_x_right) && $stable(m_y_upper)
            && $stable(m_last))
        else $error("result changed while stalled");

    // A waiting input transfer must keep its payload until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_cmd) && $stable(s_center_x)
            && $stable(s_center_y) && $stable(s_radius_x) && $stable(s_radius_y))
        else $error("input changed while waiting");

    // The input is not ready in the cycle after an accepted item.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    // Only a real point can end an ellipse, and an empty result has zero right and lower coordinates.
    a_last_real: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> !m_last && (m_x_right == '0) && (m_y_lower == '0))
        else $error("empty result carries point data");

    // Mirrored coordinates differ by twice the offset, so their low bits agree.
    a_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_x_right[0] == m_x_left[0]) && (m_y_lower[0] == m_y_upper[0]))
        else $error("mirrored coordinates are inconsistent");

endmodule

bind midpoint_ellipse_rasterizer_top emr_checker #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
) u_emr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_cmd       (s_cmd),
    .s_center_x  (s_center_x),
    .s_center_y  (s_center_y),
    .s_radius_x  (s_radius_x),
    .s_radius_y  (s_radius_y),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_valid_res (m_valid_res),
    .m_x_right   (m_x_right),
    .m_x_left    (m_x_left),
    .m_y_lower   (m_y_lower),
    .m_y_upper   (m_y_upper),
    .m_last      (m_last)
);

`default_nettype wire
